>>> hdl/pqu_pkg.sv
// Package for the pending request queue: sizes, field widths, command and status codes,
// the stored entry type and the sequencer states.
// No dependencies; used by pending_request_queue_unit.
package pqu_pkg;

   // Queue depth and the widths that follow from it.
   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths.
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int ID_W       = 31;
   localparam int HANDLE_W   = 16;
   localparam int OCC_W      = 5;
   localparam int ENTRY_W    = ID_W + HANDLE_W;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USED_W = ID_W + HANDLE_W + 1 + ID_W + HANDLE_W + OCC_W;

   // Command codes carried on req_tuser.
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TAKE    = 2'd2;

   // Status codes carried on rsp_tuser.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // One stored queue entry.
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_SHIFT,
      ST_HEAD,
      ST_RESULT
   } state_type;

endpackage

>>> hdl/pending_request_queue_unit.sv
// Pending request queue: ordered queue of requests with enqueue, dequeue and take-by-id.
// Depends on pqu_pkg and on pqu_ram for the entry store.
//
//  channel | direction | tdata (lowest bit up)                       | tuser
//  req     | in        | request_id[30:0], payload_handle[46:31]     | command[1:0]
//  rsp     | out       | out_id, out_handle, not_empty, head_id,     | status[1:0]
//          |           | head_handle, occupancy (bits 99:95)         |
//
// An enqueue writes its entry in ST_START, then ST_HEAD reads the head entry. Dequeue and
// take-by-id run a scan pass and, when an entry is removed, a shift pass over the entry
// RAM, one entry a cycle through its single read port.
// The block accepts one request at a time; a new request is taken while the previous
// result still waits on rsp, and that result must be taken before the next one is loaded.
// Reset clears the state, the occupancy and the valid flags; the entry RAM needs no clearing pass.
module pending_request_queue_unit
   import pqu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // request_id[30:0], payload_handle[46:31]
   input  logic [CMD_W-1:0]      req_tuser,  // command[1:0]
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_id[30:0], out_handle[46:31],
                                             // not_empty[47], head_id[78:48],
                                             // head_handle[94:79], occupancy[99:95]
   output logic [STATUS_W-1:0]   rsp_tuser   // status[1:0]
);

   // Sequencer and queue state.
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   entry_type             req_entry_ff, req_entry_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]     rd_tag_ff, rd_tag_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   entry_type             out_entry_ff, out_entry_in;

   // Result register.
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [STATUS_W-1:0]   rsp_tuser_ff, rsp_tuser_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Entry RAM ports.
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   entry_type             wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   entry_type             rd_data;
   logic [ENTRY_W-1:0]    rd_word;

   // Helper terms.
   logic                  req_xfer;
   logic                  rsp_free;
   logic                  more_to_read;
   logic                  match;
   entry_type             head_entry;

   pqu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_data = rd_word;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_xfer     = req_tvalid && req_tready;
   assign rsp_free     = !rsp_tvalid_ff || rsp_tready;
   assign more_to_read = (idx_ff < count_ff);
   assign match        = rd_valid_ff && ((cmd_ff == CMD_DEQUEUE) || (rd_data.id == req_entry_ff.id));
   assign head_entry   = (count_ff != '0) ? rd_data : '0;

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_ff       <= cmd_in;
      req_entry_ff <= req_entry_in;
      idx_ff       <= idx_in;
      rd_tag_ff    <= rd_tag_in;
      status_ff    <= status_in;
      out_entry_ff <= out_entry_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // Sequencer: next state, RAM controls and result loading.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      req_entry_in  = req_entry_ff;
      idx_in        = idx_ff;
      rd_valid_in   = 1'b0;
      rd_tag_in     = rd_tag_ff;
      status_in     = status_ff;
      out_entry_in  = out_entry_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_tag_ff - ADDR_W'(1);
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[ADDR_W-1:0];

      // Reads for the scan and shift passes go out one address a cycle.
      if ((state_ff == ST_SCAN || state_ff == ST_SHIFT) && more_to_read) begin
         rd_en       = 1'b1;
         rd_valid_in = 1'b1;
         rd_tag_in   = idx_ff[ADDR_W-1:0];
         idx_in      = idx_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in              = req_tuser;
               req_entry_in.id     = req_tdata[ID_W-1:0];
               req_entry_in.handle = req_tdata[ID_W+HANDLE_W-1:ID_W];
               state_in            = ST_START;
            end
         end
         ST_START: begin
            status_in    = STATUS_EMPTY;
            out_entry_in = '0;
            idx_in       = '0;
            case (cmd_ff)
               CMD_ENQUEUE: begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = count_ff[ADDR_W-1:0];
                     wr_data   = req_entry_ff;
                     count_in  = count_ff + CNT_W'(1);
                     status_in = STATUS_OK;
                  end
                  state_in = ST_HEAD;
               end
               CMD_DEQUEUE, CMD_TAKE: begin
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_HEAD;
               end
            endcase
         end
         ST_SCAN: begin
            // Compare the entry read last cycle; dequeue takes the first entry.
            if (match) begin
               out_entry_in = rd_data;
               status_in    = STATUS_OK;
               state_in     = ST_SHIFT;
            end else if (!more_to_read) begin
               state_in = ST_HEAD;
            end
         end
         ST_SHIFT: begin
            // Move each later entry down by one slot to close the gap.
            if (rd_valid_ff) begin
               wr_en = 1'b1;
            end
            if (!more_to_read) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = status_ff;
               rsp_tdata_in  = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                                OCC_W'(count_ff),
                                head_entry.handle,
                                head_entry.id,
                                (count_ff != '0),
                                out_entry_ff.handle,
                                out_entry_ff.id};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTHESIS
   // The queue never holds more than DEPTH entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy above depth");

   // Shift writes only land inside the occupied part of the queue.
   a_shift_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && wr_en) |-> (CNT_W'(wr_addr) < count_ff))
      else $error("shift write outside the occupied entries");

   // Occupancy changes only when an enqueue starts or a removal finishes.
   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
      ($past(state_ff) == ST_START || $past(state_ff) == ST_SHIFT))
      else $error("occupancy changed outside enqueue or removal");

   // A new result is only loaded at the end of the sequence.
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_tvalid_ff)) |-> ($past(state_ff) == ST_RESULT))
      else $error("result loaded outside the result state");
`endif

endmodule

>>> hdl/pqu_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// No dependencies; used by pending_request_queue_unit for the entry store.
module pqu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> tb/tb_pending_request_queue_unit.sv
// Self-checking testbench for pending_request_queue_unit: directed and random request streams
// with random idling on both channels, checked against a queue-based prediction of each result.
// Depends on pqu_pkg and the RTL of pending_request_queue_unit and pqu_ram only.
module tb_pending_request_queue_unit
   import pqu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The fourth command code is unused by the block and must be ignored.
   localparam logic [CMD_W-1:0]    CMD_UNUSED   = 2'd3;
   localparam logic [ID_W-1:0]     ID_MAX       = 31'h7FFF_FFFE;
   localparam logic [HANDLE_W-1:0] HANDLE_MAX   = 16'hFFFF;
   localparam int                  RANDOM_COUNT = 1600;
   localparam int                  DRAIN_CYCLES = 4 * (DEPTH + 5);
   localparam int                  CYCLE_LIMIT  = 400000;

   // One planned request with the idle cycles that precede it.
   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
      logic [3:0]          gap;
   } request_item_type;

   // The fields of one result, as the block reports them.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_id;
      logic [HANDLE_W-1:0] out_handle;
      logic                not_empty;
      logic [ID_W-1:0]     head_id;
      logic [HANDLE_W-1:0] head_handle;
      logic [OCC_W-1:0]    occupancy;
   } queue_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // request_id[30:0], payload_handle[46:31]
   logic [CMD_W-1:0]      req_tuser = '0;  // command[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // out_id, out_handle, not_empty, head_id,
                                           // head_handle, occupancy
   logic [STATUS_W-1:0]   rsp_tuser;       // status[1:0]

   request_item_type request_plan[$];
   request_item_type loaded_item;
   logic             item_loaded = 1'b0;
   logic [ID_W-1:0]  planned_ids[$];
   int               planned_count = 0;
   int               requests_taken = 0;

   entry_type        held_entries[$];
   queue_result_type expected_results[$];
   int               results_seen = 0;
   int               stall_left = 0;
   int               mismatch_count = 0;
   int               cycle_count = 0;

   pending_request_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one request to the held entries and returns the result it should produce.
   function automatic queue_result_type step_queue(input logic [CMD_W-1:0]    cmd,
                                                   input logic [ID_W-1:0]     id,
                                                   input logic [HANDLE_W-1:0] handle);
      queue_result_type res;
      entry_type        fresh;
      int               pos;
      res = '0;
      res.status = STATUS_EMPTY;
      pos = -1;
      case (cmd)
         CMD_ENQUEUE: begin
            if (held_entries.size() >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               fresh.id = id;
               fresh.handle = handle;
               held_entries.push_back(fresh);
               res.status = STATUS_OK;
            end
         end
         CMD_DEQUEUE: begin
            if (held_entries.size() > 0) pos = 0;
         end
         CMD_TAKE: begin
            // The oldest matching entry wins.
            for (int k = 0; k < held_entries.size() && pos < 0; k++)
               if (held_entries[k].id == id) pos = k;
         end
         default: ;
      endcase
      if (pos >= 0) begin
         res.out_id = held_entries[pos].id;
         res.out_handle = held_entries[pos].handle;
         res.status = STATUS_OK;
         held_entries.delete(pos);
      end
      res.not_empty = (held_entries.size() > 0);
      if (res.not_empty) begin
         res.head_id = held_entries[0].id;
         res.head_handle = held_entries[0].handle;
      end
      res.occupancy = OCC_W'(held_entries.size());
      return res;
   endfunction

   // Queues one request for the driver and tracks which ids it leaves in the queue,
   // so that later take-by-id requests can aim at ids actually held.
   task automatic add_request(input logic [CMD_W-1:0]    cmd,
                              input logic [ID_W-1:0]     id,
                              input logic [HANDLE_W-1:0] handle);
      request_item_type item;
      int               pos;
      item.cmd = cmd;
      item.id = id;
      item.handle = handle;
      // Every third stretch of 64 requests arrives back to back.
      item.gap = ((planned_count / 64) % 3 == 0) ? 4'd0 : 4'($urandom_range(0, 9));
      request_plan.push_back(item);
      planned_count++;
      pos = -1;
      if (cmd == CMD_ENQUEUE && planned_ids.size() < DEPTH) begin
         planned_ids.push_back(id);
      end else if (cmd == CMD_DEQUEUE && planned_ids.size() > 0) begin
         pos = 0;
      end else if (cmd == CMD_TAKE) begin
         for (int k = 0; k < planned_ids.size() && pos < 0; k++)
            if (planned_ids[k] == id) pos = k;
      end
      if (pos >= 0) planned_ids.delete(pos);
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                   results_seen, name, got, want));
   endtask

   // Request driver: presents planned requests after their idle gaps and predicts the
   // result of each one at its transfer.
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(step_queue(req_tuser, req_tdata[ID_W-1:0],
                                                  req_tdata[ENTRY_W-1:ID_W]));
            requests_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (!item_loaded && request_plan.size() != 0) begin
               loaded_item = request_plan.pop_front();
               item_loaded = 1'b1;
            end
            next_valid = 1'b0;
            if (item_loaded) begin
               if (loaded_item.gap == 0) begin
                  req_tdata <= {{(REQ_DATA_W - ENTRY_W){1'b0}}, loaded_item.handle,
                                loaded_item.id};
                  req_tuser <= loaded_item.cmd;
                  next_valid = 1'b1;
                  item_loaded = 1'b0;
               end else begin
                  loaded_item.gap = loaded_item.gap - 4'd1;
               end
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // Result monitor: compares each result transfer with the oldest prediction and, in alternate
   // stretches of 64 results, stalls the result channel at random after each one.
   always @(posedge clock) begin
      queue_result_type got;
      queue_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            {got.occupancy, got.head_handle, got.head_id, got.not_empty,
             got.out_handle, got.out_id} = rsp_tdata[RSP_USED_W-1:0];
            if (expected_results.size() == 0) begin
               report_mismatch("result transfer with no request pending");
            end else begin
               want = expected_results.pop_front();
               check_field("status", 32'(got.status), 32'(want.status));
               check_field("out_id", 32'(got.out_id), 32'(want.out_id));
               check_field("out_handle", 32'(got.out_handle), 32'(want.out_handle));
               check_field("not_empty", 32'(got.not_empty), 32'(want.not_empty));
               check_field("head_id", 32'(got.head_id), 32'(want.head_id));
               check_field("head_handle", 32'(got.head_handle), 32'(want.head_handle));
               check_field("occupancy", 32'(got.occupancy), 32'(want.occupancy));
            end
            results_seen++;
            // Alternate stretches of 64 results with and without stalls.
            stall_left = ((results_seen / 64) % 2 == 0) ? 0 : $urandom_range(0, 9);
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pending_request_queue_unit verification failed");
         $finish;
      end
   end

   // Stimulus plan, reset and end of run.
   initial begin
      int                  counted;
      int                  phase;
      int                  roll;
      logic [CMD_W-1:0]    cmd;
      logic [ID_W-1:0]     id;

      // Empty queue: dequeue, take and the unused code all report empty.
      add_request(CMD_DEQUEUE, ID_MAX, HANDLE_MAX);
      add_request(CMD_TAKE, '0, '0);
      add_request(CMD_UNUSED, ID_MAX, HANDLE_MAX);
      // Field extremes and alternating bit patterns, with a duplicated id.
      add_request(CMD_ENQUEUE, '0, '0);
      add_request(CMD_ENQUEUE, ID_MAX, HANDLE_MAX);
      add_request(CMD_ENQUEUE, 31'h2AAA_AAAA, 16'h5555);
      add_request(CMD_ENQUEUE, 31'h5555_5555, 16'hAAAA);
      add_request(CMD_ENQUEUE, ID_MAX, 16'h1234);
      // Take by id removes the older of the two duplicates from mid-queue.
      add_request(CMD_TAKE, ID_MAX, '0);
      // Take with no match on a non-empty queue, and the unused code with data.
      add_request(CMD_TAKE, 31'h1111_1111, '0);
      add_request(CMD_UNUSED, 31'h0F0F_0F0F, 16'hF0F0);
      add_request(CMD_DEQUEUE, '0, '0);
      // Fill to the limit, then one enqueue that must be dropped.
      for (int k = 0; k < DEPTH - 3; k++)
         add_request(CMD_ENQUEUE, 31'(k + 100), 16'(k * 16'h0101));
      add_request(CMD_ENQUEUE, 31'h7777_7777, 16'h7777);
      // Take the entry at the tail of a full queue.
      add_request(CMD_TAKE, 31'(DEPTH - 4 + 100), '0);

      // Random part in phases that favour filling, draining or a mix.
      counted = 0;
      while (counted < RANDOM_COUNT) begin
         phase = (counted / 40) % 3;
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 4) cmd = CMD_UNUSED;
         else if (phase == 0) cmd = (roll < 70) ? CMD_ENQUEUE : (roll < 82) ? CMD_DEQUEUE : CMD_TAKE;
         else if (phase == 1) cmd = (roll < 20) ? CMD_ENQUEUE : (roll < 55) ? CMD_DEQUEUE : CMD_TAKE;
         else cmd = (roll < 40) ? CMD_ENQUEUE : (roll < 65) ? CMD_DEQUEUE : CMD_TAKE;
         id = 31'($urandom_range(0, ID_MAX));
         // Takes mostly aim at held ids; some enqueues duplicate a held id.
         if (planned_ids.size() > 0 &&
             ((cmd == CMD_TAKE && $urandom_range(0, 3) != 0) ||
              (cmd == CMD_ENQUEUE && $urandom_range(0, 4) == 0)))
            id = planned_ids[$urandom_range(0, planned_ids.size() - 1)];
         add_request(cmd, id, 16'($urandom_range(0, HANDLE_MAX)));
         if (cmd != CMD_UNUSED) counted++;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (requests_taken != planned_count) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("pending_request_queue_unit verification clean");
      end else begin
         $display("pending_request_queue_unit verification failed");
      end
      $finish;
   end

endmodule

>>> pending_request_queue_unit.f
hdl/pqu_pkg.sv
hdl/pqu_ram.sv
hdl/pending_request_queue_unit.sv
tb/tb_pending_request_queue_unit.sv
